### sv/ffsa_pkg.sv
// Shared types and constants for the first-fit segment allocator.
// No dependencies.
`default_nettype none
package ffsa_pkg;
  localparam int unsigned DefMaxSegments = 16;
  localparam logic [16:0] DefTotalSize   = 17'd1024;
  localparam logic [16:0] RegionLimit    = 17'd65536;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_FULL    = 2'd2,
    ST_BAD_OFF = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_SPLIT,
    S_FREE_NXT_RD,
    S_FREE_NXT,
    S_FREE_PRV_RD,
    S_FREE_PRV,
    S_REMOVE_RD,
    S_REMOVE_WR,
    S_DONE
  } state_e;

  // One table entry.
  typedef struct packed {
    logic [15:0] offset;
    logic [16:0] size;
    logic        alloc;
  } seg_t;
endpackage
`default_nettype wire

### sv/first_fit_segment_allocator_unit.sv
// Top level of the first-fit segment allocator with coalescing.
// Depends on ffsa_pkg.
//
// Each item scans the table entry by entry, then moves entries up when a split inserts an entry
// or down when a merge removes one.
// Each state makes at most one access, a read or a write, to the segment table.
// Throughput: one item at a time; the next item is taken once the result beat is accepted.
// Reset: asynchronous, active low; the table holds one free segment of 1024 units.
// A total_size write re-initializes the table (count and entry 0 only).
`default_nettype none
module first_fit_segment_allocator_unit
  import ffsa_pkg::*;
#(
  parameter int unsigned MaxSegments = DefMaxSegments
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [16:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic        mode_i,
  input  wire logic [16:0] req_size_i,
  input  wire logic [15:0] free_offset_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [1:0]  status_o,
  output      logic [15:0] seg_offset_o,
  output      logic [16:0] seg_size_o
);
  localparam int unsigned IdxW = $clog2(MaxSegments);
  localparam int unsigned CntW = $clog2(MaxSegments + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxSegments);

  // Segment table memory; entry 0 is held apart in a register so a re-init can write it directly.
  seg_t mem_q [MaxSegments];
  seg_t rd_q;
  seg_t ent0_q, ent0_d;
  logic e0_sel_q;

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] idx_q, idx_d;   // found entry
  logic [IdxW-1:0] ptr_q, ptr_d;   // shift pointer
  logic            mode_q;
  logic [16:0]     req_q;
  logic [15:0]     off_q;
  seg_t            cur_q, cur_d;   // entry being modified
  logic            out_valid_q, out_valid_d;
  status_e         st_q, st_d;
  logic [15:0]     ooff_q, ooff_d;
  logic [16:0]     osz_q, osz_d;
  logic            mode_d;
  logic [16:0]     req_d;
  logic [15:0]     off_d;

  // Memory port controls
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  seg_t            wr_data;
  seg_t            rdata;
  logic [16:0]     cfg_sat;

  assign rdata       = e0_sel_q ? ent0_q : rd_q;
  assign cfg_ready_o = (state_q == S_IDLE) && !out_valid_q;
  assign in_stall_o  = (state_q != S_IDLE) || out_valid_q;
  assign cfg_sat     = (cfg_data_i > RegionLimit) ? RegionLimit : cfg_data_i;

  // Memory with registered read
  always_ff @(posedge clk_i) begin
    if (wr_en && wr_addr != '0) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i && !in_stall_o) begin
        state_d = mode_i ? S_SCAN_RD : ((req_size_i == '0) ? S_DONE : S_SCAN_RD);
      end
      S_SCAN_RD:  state_d = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (!mode_q && !rdata.alloc && rdata.size >= req_q) begin
          if (rdata.size == req_q) state_d = S_DONE;
          else if (cnt_q >= CntMax) state_d = S_DONE;
          else state_d = (CntW'(idx_q) + 1'b1 == cnt_q) ? S_SPLIT : S_SHIFT_RD;
        end else if (mode_q && rdata.alloc && rdata.offset == off_q) begin
          state_d = (CntW'(idx_q) + 1'b1 < cnt_q) ? S_FREE_NXT_RD : S_FREE_PRV_RD;
        end else if (CntW'(idx_q) + 1'b1 >= cnt_q) begin
          state_d = S_DONE;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: state_d = S_SHIFT_WR;
      S_SHIFT_WR: state_d = (ptr_q == idx_q + 1'b1) ? S_SPLIT : S_SHIFT_RD;
      S_SPLIT:    state_d = S_DONE;
      S_FREE_NXT_RD: state_d = S_FREE_NXT;
      S_FREE_NXT: state_d = (!rdata.alloc) ?
          ((CntW'(idx_q) + 2'd2 < cnt_q) ? S_REMOVE_RD : S_FREE_PRV_RD) : S_FREE_PRV_RD;
      S_REMOVE_RD: state_d = S_REMOVE_WR;
      S_REMOVE_WR: state_d = (CntW'(ptr_q) + 1'b1 >= cnt_q) ? S_FREE_PRV_RD : S_REMOVE_RD;
      S_FREE_PRV_RD: state_d = (idx_q == '0) ? S_DONE : S_FREE_PRV;
      S_FREE_PRV: state_d = (!rdata.alloc && CntW'(idx_q) + 1'b1 < cnt_q) ? S_REMOVE_RD
                                                                        : S_DONE;
      S_DONE:     state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    cnt_d = cnt_q; idx_d = idx_q; ptr_d = ptr_q; cur_d = cur_q;
    mode_d = mode_q; req_d = req_q; off_d = off_q;
    ent0_d = ent0_q;
    out_valid_d = out_valid_q && out_stall_i;
    st_d = st_q; ooff_d = ooff_q; osz_d = osz_q;
    rd_en = 1'b0; rd_addr = idx_q;
    wr_en = 1'b0; wr_addr = idx_q; wr_data = cur_q;
    case (state_q)
      S_IDLE: begin
        if (cfg_valid_i && cfg_ready_o) begin
          ent0_d = '{offset: '0, size: cfg_sat, alloc: 1'b0};
          cnt_d  = CntW'(1);
        end
        if (in_valid_i && !in_stall_o) begin
          mode_d = mode_i; req_d = req_size_i; off_d = free_offset_i;
          idx_d = '0; st_d = mode_i ? ST_BAD_OFF : ST_NO_FIT;
          ooff_d = '0; osz_d = '0;
        end
      end
      S_SCAN_RD: begin rd_en = 1'b1; rd_addr = idx_q; end
      S_SCAN_CHK: begin
        cur_d = rdata;
        if (!mode_q && !rdata.alloc && rdata.size >= req_q) begin
          if (rdata.size != req_q && cnt_q >= CntMax) begin
            st_d = ST_FULL;
          end else begin
            st_d = ST_OK; ooff_d = rdata.offset; osz_d = req_q;
            ptr_d = IdxW'(cnt_q);
            // Mark the front part allocated; a split writes the remainder later
            wr_en = 1'b1; wr_data = '{offset: rdata.offset, size: req_q, alloc: 1'b1};
          end
        end else if (mode_q && rdata.alloc && rdata.offset == off_q) begin
          st_d = ST_OK;
          cur_d.alloc = 1'b0;
          wr_en = 1'b1; wr_data = '{offset: rdata.offset, size: rdata.size, alloc: 1'b0};
          ooff_d = rdata.offset; osz_d = rdata.size;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      // Move entries up one place, from the top down
      S_SHIFT_RD: begin rd_en = 1'b1; rd_addr = ptr_q - 1'b1; end
      S_SHIFT_WR: begin
        wr_en = 1'b1; wr_addr = ptr_q; wr_data = rdata;
        ptr_d = ptr_q - 1'b1;
      end
      // Write the free remainder after the allocated front
      S_SPLIT: begin
        wr_en = 1'b1; wr_addr = idx_q + 1'b1;
        wr_data = '{offset: cur_q.offset + req_q[15:0], size: cur_q.size - req_q,
                    alloc: 1'b0};
        cnt_d = cnt_q + 1'b1;
      end
      S_FREE_NXT_RD: begin rd_en = 1'b1; rd_addr = idx_q + 1'b1; end
      S_FREE_NXT: begin
        if (!rdata.alloc) begin
          cur_d.size = cur_q.size + rdata.size;
          wr_en = 1'b1; wr_data = '{offset: cur_q.offset, size: cur_q.size + rdata.size,
                                    alloc: 1'b0};
          osz_d = cur_q.size + rdata.size;
          cnt_d = cnt_q - 1'b1;
          ptr_d = idx_q + 1'b1;  // remove this slot
        end
      end
      // Move entries down one place; cnt_q already reduced
      S_REMOVE_RD: begin rd_en = 1'b1; rd_addr = ptr_q + 1'b1; end
      S_REMOVE_WR: begin
        wr_en = 1'b1; wr_addr = ptr_q; wr_data = rdata;
        ptr_d = ptr_q + 1'b1;
      end
      S_FREE_PRV_RD: begin
        if (idx_q != '0) begin rd_en = 1'b1; rd_addr = idx_q - 1'b1; end
      end
      S_FREE_PRV: begin
        if (!rdata.alloc) begin
          wr_en = 1'b1; wr_addr = idx_q - 1'b1;
          wr_data = '{offset: rdata.offset, size: rdata.size + cur_q.size, alloc: 1'b0};
          ooff_d = rdata.offset; osz_d = rdata.size + cur_q.size;
          cnt_d = cnt_q - 1'b1;
          ptr_d = idx_q;
          idx_d = '0;  // no further previous merge
        end
      end
      S_DONE: out_valid_d = 1'b1;
      default: ;
    endcase
    if (wr_en && wr_addr == '0) ent0_d = wr_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= CntW'(1); out_valid_q <= 1'b0;
      ent0_q <= '{offset: '0, size: DefTotalSize, alloc: 1'b0};
      e0_sel_q <= 1'b0; st_q <= ST_OK;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; out_valid_q <= out_valid_d;
      ent0_q <= ent0_d; st_q <= st_d;
      if (rd_en) e0_sel_q <= (rd_addr == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; ptr_q <= ptr_d; cur_q <= cur_d;
    mode_q <= mode_d; req_q <= req_d; off_q <= off_d;
    ooff_q <= ooff_d; osz_q <= osz_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = st_q;
  assign seg_offset_o = (st_q == ST_OK) ? ooff_q : '0;
  assign seg_size_o   = (st_q == ST_OK) ? osz_q : '0;

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != '0 && cnt_q <= CntMax) else $error("segment count out of range");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o) else $error("accept while busy");
  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |=> out_valid_q) else $error("result lost");
`endif
endmodule
`default_nettype wire
